// ----- rtl/gnga_pkg.sv -----
// Shared types and constants for the greedy nearest-goal assignment block.
package gnga_pkg;

	// Fixed field widths of the transaction payloads
	localparam int FUNC_W   = 2;
	localparam int PT_W     = 10;
	localparam int STATUS_W = 2;
	localparam int DIST_W   = 21;
	localparam int LEFT_W   = 7;

	typedef logic [PT_W-1:0]   pt_t;
	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [LEFT_W-1:0] left_t;
	typedef logic [FUNC_W-1:0] func_raw_t;

	// Command codes; the fourth code is unused and ignored
	typedef enum logic [FUNC_W-1:0] {
		FN_CLEAR  = 2'd0,
		FN_INSERT = 2'd1,
		FN_ASSIGN = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_DUP   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	// Broadcast control to every cell of the ring
	typedef struct packed {
		logic shift;
		logic clear;
	} ring_ctrl_t;

	// Outcome flags of one scan pass
	typedef struct packed {
		logic found;
		logic dup;
		logic free_found;
	} scan_flags_t;

endpackage

// ----- rtl/gnga_cmd_if.sv -----
// Command channel: function code and grid point.
interface gnga_cmd_if;
	import gnga_pkg::*;

	logic      valid;
	logic      ready;
	func_raw_t func;
	pt_t       point_x;
	pt_t       point_y;

	modport source(output valid, output func, output point_x, output point_y, input ready);
	modport sink(input valid, input func, input point_x, input point_y, output ready);
endinterface

// ----- rtl/gnga_rsp_if.sv -----
// Result channel: status, assigned goal, distance and goals left.
interface gnga_rsp_if;
	import gnga_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	pt_t     goal_x;
	pt_t     goal_y;
	dist_t   sq_distance;
	left_t   goals_left;

	modport source(output valid, output status, output goal_x, output goal_y,
		output sq_distance, output goals_left, input ready);
	modport sink(input valid, input status, input goal_x, input goal_y,
		input sq_distance, input goals_left, output ready);
endinterface

// ----- rtl/greedy_nearest_goal_assign.sv -----
// Top level: goal ring, head distance unit, control sequencer and result register.
//
//  channel | dir | payload                                            | accepted when
//  cmd     | in  | func, point_x, point_y                             | valid & ready
//  rsp     | out | status, goal_x, goal_y, sq_distance, goals_left    | valid & ready
//
// Insert and assign rotate the ring once past the distance unit, then pass a
// drain step before the result is registered. Clear and the unused code skip both.
// One command is in flight at a time; cmd.ready is high whenever the sequencer
// is idle, even while a result waits in the output register.
// A stalled output holds the sequencer in its final step. Reset empties the table.
module greedy_nearest_goal_assign #(
	parameter int MAX_GOALS  = 64,
	parameter int COORD_BITS = 10
) (
	input logic       clk,
	input logic       arst_n,
	gnga_cmd_if.sink  cmd,
	gnga_rsp_if.source rsp
);
	import gnga_pkg::*;

	localparam int IDXW = $clog2(MAX_GOALS);
	localparam int CNTW = $clog2(MAX_GOALS + 1);
	localparam int CW   = COORD_BITS;
	localparam int DW   = 2 * COORD_BITS + 1;
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MAX_GOALS - 1);

	state_t          state_q, state_d;
	func_raw_t       func_q;
	logic [CW-1:0]   px_q;
	logic [CW-1:0]   py_q;
	logic [IDXW-1:0] step_q;
	logic [CNTW-1:0] count_q, count_d;

	ring_ctrl_t      ring;
	logic            wr_en;
	logic            kill_en;
	logic            start;
	logic            accept;
	logic            out_load;
	logic            out_free;

	logic [CW-1:0]        cx [MAX_GOALS];
	logic [CW-1:0]        cy [MAX_GOALS];
	logic [MAX_GOALS-1:0] cv;

	scan_flags_t     flags;
	logic [IDXW-1:0] best_idx;
	logic [CW-1:0]   best_x;
	logic [CW-1:0]   best_y;
	logic [DW-1:0]   best_d;
	logic [IDXW-1:0] free_idx;

	status_t status_d;
	pt_t     gx_d, gy_d;
	dist_t   dist_d;

	logic    rsp_valid_q;
	status_t rsp_status_q;
	pt_t     rsp_gx_q;
	pt_t     rsp_gy_q;
	dist_t   rsp_dist_q;
	left_t   rsp_left_q;

	// Ring of goal cells; cell i takes its contents from cell i+1
	for (genvar i = 0; i < MAX_GOALS; i++) begin : g_cell
		gnga_cell #(.CW(CW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ring),
			.wr        (wr_en && (free_idx == IDXW'(i))),
			.kill      (kill_en && (best_idx == IDXW'(i))),
			.wr_x      (px_q),
			.wr_y      (py_q),
			.nxt_x     (cx[(i + 1) % MAX_GOALS]),
			.nxt_y     (cy[(i + 1) % MAX_GOALS]),
			.nxt_valid (cv[(i + 1) % MAX_GOALS]),
			.x         (cx[i]),
			.y         (cy[i]),
			.valid     (cv[i])
		);
	end

	// Distance unit looks at cell 0
	gnga_scan #(.CW(CW), .IDXW(IDXW)) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.feed       (ring.shift),
		.idx        (step_q),
		.head_x     (cx[0]),
		.head_y     (cy[0]),
		.head_valid (cv[0]),
		.px         (px_q),
		.py         (py_q),
		.flags      (flags),
		.best_idx   (best_idx),
		.best_x     (best_x),
		.best_y     (best_y),
		.best_d     (best_d),
		.free_idx   (free_idx)
	);

	assign out_free = !rsp_valid_q || rsp.ready;
	assign accept   = cmd.valid && cmd.ready;

	// Sequencer: next state and per-command outcome
	always_comb begin
		state_d    = state_q;
		cmd.ready  = (state_q == S_IDLE);
		ring.shift = 1'b0;
		ring.clear = 1'b0;
		wr_en      = 1'b0;
		kill_en    = 1'b0;
		start      = 1'b0;
		out_load   = 1'b0;
		count_d    = count_q;
		status_d   = STAT_OK;
		gx_d       = '0;
		gy_d       = '0;
		dist_d     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					start = 1'b1;
					if ((cmd.func == FN_INSERT) || (cmd.func == FN_ASSIGN)) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_SCAN: begin
				ring.shift = 1'b1;
				if (step_q == LAST_IDX) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
					unique case (func_q)
						FN_CLEAR: begin
							ring.clear = 1'b1;
							count_d    = '0;
						end
						FN_INSERT: begin
							priority if (flags.dup) begin
								status_d = STAT_DUP;
							end else if (!flags.free_found) begin
								status_d = STAT_FULL;
							end else begin
								wr_en   = 1'b1;
								count_d = count_q + CNTW'(1);
							end
						end
						FN_ASSIGN: begin
							if (!flags.found) begin
								status_d = STAT_EMPTY;
							end else begin
								kill_en = 1'b1;
								count_d = count_q - CNTW'(1);
								gx_d    = PT_W'(best_x);
								gy_d    = PT_W'(best_y);
								dist_d  = DIST_W'(best_d);
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (start) begin
				step_q <= '0;
			end else if (ring.shift) begin
				step_q <= step_q + IDXW'(1);
			end
		end
	end

	// Command capture
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= cmd.func;
			px_q   <= CW'(cmd.point_x);
			py_q   <= CW'(cmd.point_y);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_status_q <= status_d;
			rsp_gx_q     <= gx_d;
			rsp_gy_q     <= gy_d;
			rsp_dist_q   <= dist_d;
			rsp_left_q   <= LEFT_W'(count_d);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.goal_x      = rsp_gx_q;
	assign rsp.goal_y      = rsp_gy_q;
	assign rsp.sq_distance = rsp_dist_q;
	assign rsp.goals_left  = rsp_left_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_GOALS))
		else $error("goal count above table size");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cv) == int'(count_q))
		else $error("goal count differs from number of valid cells");

	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) && (step_q != LAST_IDX) |=>
		(state_q == S_SCAN) && (step_q == $past(step_q) + IDXW'(1)))
		else $error("ring rotation interrupted");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("sequencer idle right after a transaction was taken");

endmodule

// ----- rtl/gnga_cell.sv -----
// One goal slot of the rotating ring: coordinates plus valid bit.
module gnga_cell #(
	parameter int CW = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gnga_pkg::ring_ctrl_t ctrl,
	input  logic                 wr,
	input  logic                 kill,
	input  logic [CW-1:0]        wr_x,
	input  logic [CW-1:0]        wr_y,
	input  logic [CW-1:0]        nxt_x,
	input  logic [CW-1:0]        nxt_y,
	input  logic                 nxt_valid,
	output logic [CW-1:0]        x,
	output logic [CW-1:0]        y,
	output logic                 valid
);
	import gnga_pkg::*;

	logic [CW-1:0] x_q;
	logic [CW-1:0] y_q;
	logic          valid_q;

	// Valid bit: clear beats write beats kill beats rotate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			priority if (ctrl.clear) begin
				valid_q <= 1'b0;
			end else if (wr) begin
				valid_q <= 1'b1;
			end else if (kill) begin
				valid_q <= 1'b0;
			end else if (ctrl.shift) begin
				valid_q <= nxt_valid;
			end else begin
				valid_q <= valid_q;
			end
		end
	end

	// Coordinates, no reset; write and rotate never coincide
	always_ff @(posedge clk) begin
		if (wr) begin
			x_q <= wr_x;
			y_q <= wr_y;
		end else if (ctrl.shift) begin
			x_q <= nxt_x;
			y_q <= nxt_y;
		end
	end

	assign x     = x_q;
	assign y     = y_q;
	assign valid = valid_q;

endmodule

// ----- rtl/gnga_scan.sv -----
// Distance unit at the ring head: squares, then compare and keep the best.
module gnga_scan #(
	parameter int CW   = 10,
	parameter int IDXW = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  feed,
	input  logic [IDXW-1:0]       idx,
	input  logic [CW-1:0]         head_x,
	input  logic [CW-1:0]         head_y,
	input  logic                  head_valid,
	input  logic [CW-1:0]         px,
	input  logic [CW-1:0]         py,
	output gnga_pkg::scan_flags_t flags,
	output logic [IDXW-1:0]       best_idx,
	output logic [CW-1:0]         best_x,
	output logic [CW-1:0]         best_y,
	output logic [2*CW:0]         best_d,
	output logic [IDXW-1:0]       free_idx
);
	import gnga_pkg::*;

	localparam int SQW = 2 * CW;
	localparam int DW  = SQW + 1;

	logic [CW-1:0]   dx;
	logic [CW-1:0]   dy;
	logic            feed_s1;
	logic            valid_s1;
	logic            dup_s1;
	logic [IDXW-1:0] idx_s1;
	logic [CW-1:0]   x_s1;
	logic [CW-1:0]   y_s1;
	logic [SQW-1:0]  sqx_s1;
	logic [SQW-1:0]  sqy_s1;
	logic [DW-1:0]   d_sum;
	logic            better;

	scan_flags_t     flags_q;
	logic [IDXW-1:0] best_idx_q;
	logic [CW-1:0]   best_x_q;
	logic [CW-1:0]   best_y_q;
	logic [DW-1:0]   best_d_q;
	logic [IDXW-1:0] free_idx_q;

	// Absolute coordinate differences
	assign dx = (head_x >= px) ? (head_x - px) : (px - head_x);
	assign dy = (head_y >= py) ? (head_y - py) : (py - head_y);

	// Stage 1: squares and equality
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_s1 <= 1'b0;
		end else begin
			feed_s1 <= feed;
		end
	end

	always_ff @(posedge clk) begin
		valid_s1 <= head_valid;
		dup_s1   <= (head_x == px) && (head_y == py);
		idx_s1   <= idx;
		x_s1     <= head_x;
		y_s1     <= head_y;
		sqx_s1   <= SQW'(dx) * SQW'(dx);
		sqy_s1   <= SQW'(dy) * SQW'(dy);
	end

	// Stage 2: sum and strict compare, ties by x then y
	assign d_sum  = DW'(sqx_s1) + DW'(sqy_s1);
	assign better = !flags_q.found || (d_sum < best_d_q) ||
		((d_sum == best_d_q) &&
		 ((x_s1 < best_x_q) || ((x_s1 == best_x_q) && (y_s1 < best_y_q))));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			priority if (start) begin
				flags_q <= '0;
			end else if (feed_s1) begin
				if (valid_s1) begin
					if (dup_s1) begin
						flags_q.dup <= 1'b1;
					end
					if (better) begin
						flags_q.found <= 1'b1;
					end
				end else if (!flags_q.free_found) begin
					flags_q.free_found <= 1'b1;
				end
			end else begin
				flags_q <= flags_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (feed_s1 && !start) begin
			if (valid_s1 && better) begin
				best_idx_q <= idx_s1;
				best_x_q   <= x_s1;
				best_y_q   <= y_s1;
				best_d_q   <= d_sum;
			end
			if (!valid_s1 && !flags_q.free_found) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	assign flags    = flags_q;
	assign best_idx = best_idx_q;
	assign best_x   = best_x_q;
	assign best_y   = best_y_q;
	assign best_d   = best_d_q;
	assign free_idx = free_idx_q;

endmodule
